// ----- src/ssst_pkg.sv -----
// shared constants, types and register codes for the four sensor sun tracker
`timescale 1ns / 1ps
package ssst_pkg;

	// sample width of one light sensor reading
	localparam int SAMPLE_BITS = 10;

	// fixed field widths
	localparam int AVG_W = 10;
	localparam int POS_W = 9;
	localparam int TOL_W = 7;

	// working width for pair means, at least as wide as the reported field
	localparam int AW = (SAMPLE_BITS > AVG_W) ? SAMPLE_BITS : AVG_W;
	localparam int SUM_W = AW + 1;
	localparam int MSUM_W = AW + 2;

	// adaptive tolerance and settle delay
	localparam int MEAN_LIMIT = 300;
	localparam int MEAN_OFFSET = 10;
	localparam int TOL_BASE = 5;
	localparam int DLY_BASE = 100;
	localparam int FLAT_VALUE = 50;

	// 95/290 reduces to 19/58, 50/290 to 5/29
	localparam int TOL_NUM = 19;
	localparam int TOL_DEN = 58;
	localparam int DLY_NUM = 5;
	localparam int DLY_DEN = 29;
	localparam int RECIP_SHIFT = 16;
	localparam int TOL_RECIP = (1 << RECIP_SHIFT) / TOL_DEN;
	localparam int DLY_RECIP = (1 << RECIP_SHIFT) / DLY_DEN;

	// offset magnitude is at most 289, scaled products at most 5491 and 1445
	localparam int AD_W = 9;
	localparam int XW = 13;
	localparam int YW = 11;
	localparam int PX_W = XW + 11;
	localparam int PY_W = YW + 12;
	localparam int TQ_W = 7;
	localparam int DQ_W = 6;

	// axis reset values
	localparam int POS_RESET = 90;
	localparam int MIN_RESET = 0;
	localparam int MAX_RESET = 270;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERT_MIN,
		REG_VERT_MAX,
		REG_HORIZ_MIN,
		REG_HORIZ_MAX
	} cfg_reg_t;

	// one classified item waiting for the axis update
	typedef struct packed {
		logic [AVG_W-1:0] avg_top;
		logic [AVG_W-1:0] avg_bottom;
		logic [AVG_W-1:0] avg_left;
		logic [AVG_W-1:0] avg_right;
		logic [TOL_W-1:0] tolerance;
		logic [TOL_W-1:0] settle_delay;
		logic             v_move;
		logic             v_inc;
		logic             h_move;
		logic             h_inc;
	} item_t;

endpackage

// ----- src/ssst_if.sv -----
// sensor and result channel interfaces
`timescale 1ns / 1ps
interface ssst_sensor_if;
	logic                             valid;
	logic                             ready;
	logic [ssst_pkg::SAMPLE_BITS-1:0] sensor_0;
	logic [ssst_pkg::SAMPLE_BITS-1:0] sensor_1;
	logic [ssst_pkg::SAMPLE_BITS-1:0] sensor_2;
	logic [ssst_pkg::SAMPLE_BITS-1:0] sensor_3;

	modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3, input ready);
	modport sink (input valid, sensor_0, sensor_1, sensor_2, sensor_3, output ready);
endinterface

interface ssst_result_if;
	logic                       valid;
	logic                       ready;
	logic [ssst_pkg::POS_W-1:0] vert_position;
	logic [ssst_pkg::POS_W-1:0] horiz_position;
	logic                       vert_moved;
	logic                       horiz_moved;
	logic [ssst_pkg::AVG_W-1:0] avg_top;
	logic [ssst_pkg::AVG_W-1:0] avg_bottom;
	logic [ssst_pkg::AVG_W-1:0] avg_left;
	logic [ssst_pkg::AVG_W-1:0] avg_right;
	logic [ssst_pkg::TOL_W-1:0] tolerance;
	logic [ssst_pkg::TOL_W-1:0] settle_delay;

	modport source (output valid, vert_position, horiz_position, vert_moved, horiz_moved,
		avg_top, avg_bottom, avg_left, avg_right, tolerance, settle_delay, input ready);
	modport sink (input valid, vert_position, horiz_position, vert_moved, horiz_moved,
		avg_top, avg_bottom, avg_left, avg_right, tolerance, settle_delay, output ready);
endinterface

// ----- src/four_sensor_sun_tracker_step.sv -----
// top level of the four sensor dual axis sun tracker step
//
// in_ch carries one set of four light readings per transaction; out_ch
// returns one result per set: both axis positions after the step, the move
// flags, the four pair means, the tolerance and the settle delay.
// the cfg port writes the axis limits by index (vert_min, vert_max,
// horiz_min, horiz_max); write only while no set is in flight.
// a set accepted on in_ch passes front stages s1 and s2, the queue and the
// back result register before it shows on out_ch. throughput: one set per
// clock while the receiver is ready, through the two stage tolerance/delay
// divider pipeline in the front and the axis update in the back.
// the front keeps a four entry queue toward the back and accepts a new set
// only while queue plus front stages have room, so a stalled receiver
// fills the queue and then drops in_ch.ready; nothing is lost.
// reset clears the pipeline and queue, sets both positions to 90 and the
// limits to 0 and 270.
`timescale 1ns / 1ps
module four_sensor_sun_tracker_step (
	input  logic                           clk,
	input  logic                           arst_n,
	ssst_sensor_if.sink                    in_ch,
	ssst_result_if.source                  out_ch,
	input  logic                           cfg_we,
	input  logic [ssst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssst_pkg::POS_W-1:0]     cfg_data
);
	import ssst_pkg::*;

	logic              push, pop, q_not_empty;
	item_t             push_item, q_head;
	logic [QCNT_W-1:0] q_count;

	ssst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.q_count   (q_count),
		.push      (push),
		.push_item (push_item)
	);

	ssst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	ssst_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (pop),
		.out_ch      (out_ch)
	);

endmodule

// ----- src/ssst_front.sv -----
// front: accepts sensor sets, forms means, tolerance, delay and move decisions
`timescale 1ns / 1ps
module ssst_front (
	input  logic                        clk,
	input  logic                        arst_n,
	ssst_sensor_if.sink                 in_ch,
	input  logic [ssst_pkg::QCNT_W-1:0] q_count,
	output logic                        push,
	output ssst_pkg::item_t             push_item
);
	import ssst_pkg::*;

	// stage 0 combinational
	logic [SUM_W-1:0]  sum_tb, sum_bb, sum_lf, sum_rt;
	logic [AW-1:0]     top, bot, lft, rgt, mean;
	logic [MSUM_W-1:0] mean_sum;
	logic [AW:0]       dv, dh;
	logic              in_range, neg;
	logic [AD_W-1:0]   ad;
	logic [QCNT_W-1:0] occupancy;

	// stage 1
	logic              v_s1;
	logic [AVG_W-1:0]  top_s1, bot_s1, lft_s1, rgt_s1;
	logic [XW-1:0]     x_s1;
	logic [YW-1:0]     y_s1;
	logic              neg_s1, inr_s1, vinc_s1, hinc_s1;
	logic [AW-1:0]     adv_s1, adh_s1;

	// stage 2
	logic              v_s2;
	logic [AVG_W-1:0]  top_s2, bot_s2, lft_s2, rgt_s2;
	logic [XW-1:0]     x_s2;
	logic [YW-1:0]     y_s2;
	logic [TQ_W-1:0]   qx_s2;
	logic [DQ_W-1:0]   qy_s2;
	logic              neg_s2, inr_s2, vinc_s2, hinc_s2;
	logic [AW-1:0]     adv_s2, adh_s2;

	logic [PX_W-1:0]   px;
	logic [PY_W-1:0]   py;
	logic [XW-1:0]     rx;
	logic [YW-1:0]     ry;
	logic [TQ_W-1:0]   tq;
	logic [DQ_W-1:0]   dq;
	logic [TOL_W-1:0]  tol, dly;

	// room for everything already in flight plus the new set
	assign occupancy = q_count + QCNT_W'(v_s1) + QCNT_W'(v_s2);
	assign in_ch.ready = occupancy < QCNT_W'(QUEUE_DEPTH);

	always_comb begin
		sum_tb = SUM_W'(in_ch.sensor_0) + SUM_W'(in_ch.sensor_1);
		sum_bb = SUM_W'(in_ch.sensor_2) + SUM_W'(in_ch.sensor_3);
		sum_lf = SUM_W'(in_ch.sensor_0) + SUM_W'(in_ch.sensor_2);
		sum_rt = SUM_W'(in_ch.sensor_1) + SUM_W'(in_ch.sensor_3);
		top = sum_tb[AW:1];
		bot = sum_bb[AW:1];
		lft = sum_lf[AW:1];
		rgt = sum_rt[AW:1];
		mean_sum = MSUM_W'(top) + MSUM_W'(bot) + MSUM_W'(lft) + MSUM_W'(rgt);
		mean = mean_sum[MSUM_W-1:2];
		dv = {1'b0, top} - {1'b0, bot};
		dh = {1'b0, lft} - {1'b0, rgt};
		in_range = (mean != '0) && (mean < AW'(MEAN_LIMIT));
		neg = mean < AW'(MEAN_OFFSET);
		ad = neg ? AD_W'(AW'(MEAN_OFFSET) - mean) : AD_W'(mean - AW'(MEAN_OFFSET));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_ch.valid && in_ch.ready;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		top_s1  <= top[AVG_W-1:0];
		bot_s1  <= bot[AVG_W-1:0];
		lft_s1  <= lft[AVG_W-1:0];
		rgt_s1  <= rgt[AVG_W-1:0];
		x_s1    <= XW'(ad) * XW'(TOL_NUM);
		y_s1    <= YW'(ad) * YW'(DLY_NUM);
		neg_s1  <= neg;
		inr_s1  <= in_range;
		adv_s1  <= dv[AW] ? AW'(-dv) : dv[AW-1:0];
		adh_s1  <= dh[AW] ? AW'(-dh) : dh[AW-1:0];
		vinc_s1 <= !dv[AW] && (dv != '0);
		hinc_s1 <= dh[AW] || (dh == '0);
	end

	// reciprocal estimate, at most one below the true quotient
	assign px = PX_W'(x_s1) * PX_W'(TOL_RECIP);
	assign py = PY_W'(y_s1) * PY_W'(DLY_RECIP);

	always_ff @(posedge clk) begin
		top_s2  <= top_s1;
		bot_s2  <= bot_s1;
		lft_s2  <= lft_s1;
		rgt_s2  <= rgt_s1;
		x_s2    <= x_s1;
		y_s2    <= y_s1;
		qx_s2   <= px[RECIP_SHIFT +: TQ_W];
		qy_s2   <= py[RECIP_SHIFT +: DQ_W];
		neg_s2  <= neg_s1;
		inr_s2  <= inr_s1;
		adv_s2  <= adv_s1;
		adh_s2  <= adh_s1;
		vinc_s2 <= vinc_s1;
		hinc_s2 <= hinc_s1;
	end

	always_comb begin
		rx = x_s2 - XW'(qx_s2) * XW'(TOL_DEN);
		ry = y_s2 - YW'(qy_s2) * YW'(DLY_DEN);
		tq = (rx >= XW'(TOL_DEN)) ? qx_s2 + TQ_W'(1) : qx_s2;
		dq = (ry >= YW'(DLY_DEN)) ? qy_s2 + DQ_W'(1) : qy_s2;
		if (!inr_s2) begin
			tol = TOL_W'(FLAT_VALUE);
			dly = TOL_W'(FLAT_VALUE);
		end else if (neg_s2) begin
			// mean below the offset: quotients truncate toward zero
			tol = TOL_W'(TOL_BASE) - TOL_W'(tq);
			dly = TOL_W'(DLY_BASE) + TOL_W'(dq);
		end else begin
			tol = TOL_W'(TOL_BASE) + TOL_W'(tq);
			dly = TOL_W'(DLY_BASE) - TOL_W'(dq);
		end
	end

	assign push = v_s2;

	always_comb begin
		push_item.avg_top      = top_s2;
		push_item.avg_bottom   = bot_s2;
		push_item.avg_left     = lft_s2;
		push_item.avg_right    = rgt_s2;
		push_item.tolerance    = tol;
		push_item.settle_delay = dly;
		push_item.v_move       = adv_s2 > AW'(tol);
		push_item.v_inc        = vinc_s2;
		push_item.h_move       = adh_s2 > AW'(tol);
		push_item.h_inc        = hinc_s2;
	end

endmodule

// ----- src/ssst_queue.sv -----
// short queue of classified items between front and back
`timescale 1ns / 1ps
module ssst_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  ssst_pkg::item_t             push_item,
	input  logic                        pop,
	output ssst_pkg::item_t             head,
	output logic                        not_empty,
	output logic [ssst_pkg::QCNT_W-1:0] count
);
	import ssst_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

// ----- src/ssst_back.sv -----
// back: steps and clamps both axes, holds the result register and the limits
`timescale 1ns / 1ps
module ssst_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ssst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ssst_pkg::POS_W-1:0]     cfg_data,
	input  logic                           q_not_empty,
	input  ssst_pkg::item_t                q_head,
	output logic                           q_pop,
	ssst_result_if.source                  out_ch
);
	import ssst_pkg::*;

	localparam logic signed [POS_W+1:0] PSTEP = 1;

	logic [POS_W-1:0] vert_min_q, vert_max_q, horiz_min_q, horiz_max_q;
	logic [POS_W-1:0] vert_pos_q, horiz_pos_q;
	logic             out_valid_q;
	item_t            out_item_q;
	logic [POS_W-1:0] vert_next, horiz_next;

	// min is checked first, so inverted limits still give a defined answer
	function automatic logic [POS_W-1:0] step_clamp(input logic [POS_W-1:0] pos,
		input logic inc, input logic [POS_W-1:0] lo, input logic [POS_W-1:0] hi);
		logic signed [POS_W+1:0] base, p, lo_s, hi_s;
		logic [POS_W-1:0]        r;
		base = $signed({2'b00, pos});
		lo_s = $signed({2'b00, lo});
		hi_s = $signed({2'b00, hi});
		p = inc ? base + PSTEP : base - PSTEP;
		if (p < lo_s) begin
			r = lo;
		end else if (p > hi_s) begin
			r = hi;
		end else begin
			r = p[POS_W-1:0];
		end
		return r;
	endfunction

	assign q_pop = q_not_empty && (!out_valid_q || out_ch.ready);

	always_comb begin
		vert_next  = q_head.v_move ?
			step_clamp(vert_pos_q, q_head.v_inc, vert_min_q, vert_max_q) : vert_pos_q;
		horiz_next = q_head.h_move ?
			step_clamp(horiz_pos_q, q_head.h_inc, horiz_min_q, horiz_max_q) : horiz_pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_min_q  <= POS_W'(MIN_RESET);
			vert_max_q  <= POS_W'(MAX_RESET);
			horiz_min_q <= POS_W'(MIN_RESET);
			horiz_max_q <= POS_W'(MAX_RESET);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_VERT_MIN:  vert_min_q  <= cfg_data;
				REG_VERT_MAX:  vert_max_q  <= cfg_data;
				REG_HORIZ_MIN: horiz_min_q <= cfg_data;
				REG_HORIZ_MAX: horiz_max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_pos_q  <= POS_W'(POS_RESET);
			horiz_pos_q <= POS_W'(POS_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				vert_pos_q  <= vert_next;
				horiz_pos_q <= horiz_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_item_q <= q_head;
		end
	end

	// positions only change on a pop, so the state registers drive the output
	assign out_ch.valid          = out_valid_q;
	assign out_ch.vert_position  = vert_pos_q;
	assign out_ch.horiz_position = horiz_pos_q;
	assign out_ch.vert_moved     = out_item_q.v_move;
	assign out_ch.horiz_moved    = out_item_q.h_move;
	assign out_ch.avg_top        = out_item_q.avg_top;
	assign out_ch.avg_bottom     = out_item_q.avg_bottom;
	assign out_ch.avg_left       = out_item_q.avg_left;
	assign out_ch.avg_right      = out_item_q.avg_right;
	assign out_ch.tolerance      = out_item_q.tolerance;
	assign out_ch.settle_delay   = out_item_q.settle_delay;

endmodule

// ----- src/ssst_checker.sv -----
// port level checks for the sun tracker step and their bind
`timescale 1ns / 1ps
module ssst_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [ssst_pkg::POS_W-1:0] vert_position,
	input logic [ssst_pkg::AVG_W-1:0] avg_top,
	input logic [ssst_pkg::TOL_W-1:0] tolerance,
	input logic [ssst_pkg::TOL_W-1:0] settle_delay
);
	import ssst_pkg::*;

	// a stalled transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vert_position) && $stable(avg_top)
		&& $stable(tolerance) && $stable(settle_delay))
		else $error("result changed while stalled");

	a_tol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tolerance >= TOL_W'(3) && tolerance <= TOL_W'(99))
		else $error("tolerance out of range");

	a_dly_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> settle_delay >= TOL_W'(FLAT_VALUE) && settle_delay <= TOL_W'(101))
		else $error("settle delay out of range");

	// the flat delay only comes from a dark or bright mean, which also flattens tolerance
	a_flat_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && settle_delay == TOL_W'(FLAT_VALUE) |-> tolerance == TOL_W'(FLAT_VALUE))
		else $error("flat delay without flat tolerance");

endmodule

bind four_sensor_sun_tracker_step ssst_checker u_ssst_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.vert_position (out_ch.vert_position),
	.avg_top       (out_ch.avg_top),
	.tolerance     (out_ch.tolerance),
	.settle_delay  (out_ch.settle_delay)
);
